[sv/aes_block_cipher_macros.svh]
// Assertion macros for the AES cipher RTL, used by aes_ctrl.
// Expects clk and arst_n in the scope of each use.
`ifndef AES_BLOCK_CIPHER_MACROS_SVH
`define AES_BLOCK_CIPHER_MACROS_SVH

// same-cycle implication
`define AES_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AES_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/aes_pkg.sv]
// AES package: S-box tables, round transforms, controller types.
// No dependencies; imported by every AES module.
package aes_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_KEY0   = 3'd0;
	localparam logic [2:0] REG_KEY1   = 3'd1;
	localparam logic [2:0] REG_KEY2   = 3'd2;
	localparam logic [2:0] REG_KEY3   = 3'd3;
	localparam logic [2:0] REG_KEYLEN = 3'd4;

	// key length codes
	localparam logic [1:0] KLEN_128 = 2'd0;
	localparam logic [1:0] KLEN_192 = 2'd1;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	// controller states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EXPAND = 4'b0010,
		ST_FETCH  = 4'b0100,
		ST_ROUND  = 4'b1000
	} ctrl_state_t;

	typedef logic [3:0][63:0] key_regs_t;

	// controller to datapath commands
	typedef struct packed {
		logic       load_blk;
		logic       exp_we;
		logic [5:0] word_idx;
		logic       from_key;
		logic       mod_zero;
		logic       mod_four;
		logic       rd_en;
		logic [3:0] rd_row;
		logic       rnd_en;
		logic       rnd_first;
		logic       rnd_last;
		logic       dec;
	} ctrl_cmd_t;

	// key words for a key length code; code 3 acts as 256-bit
	function automatic logic [3:0] nk_of(input logic [1:0] klen);
		case (klen)
			KLEN_128: return 4'd4;
			KLEN_192: return 4'd6;
			default:  return 4'd8;
		endcase
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// byte i of the state sits at bits 127-8i down
	function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		t = '0;
		for (int i = 0; i < 16; i++) begin
			t[127-8*i -: 8] = inv ? INV_SBOX[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
		end
		return t;
	endfunction

	function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		int mv;
		int st;
		t = '0;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				mv = r + 4 * ((c + r) % 4);
				st = r + 4 * c;
				if (inv)
					t[127-8*mv -: 8] = s[127-8*st -: 8];
				else
					t[127-8*st -: 8] = s[127-8*mv -: 8];
			end
		end
		return t;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				a[k]  = s[127-8*(4*c+k) -: 8];
				x2[k] = xt(a[k]);
				x4[k] = xt(x2[k]);
				x8[k] = xt(x4[k]);
			end
			for (int r = 0; r < 4; r++) begin
				if (inv)
					t[127-8*(4*c+r) -: 8] =
						(x8[r] ^ x4[r] ^ x2[r]) ^
						(x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4]) ^
						(x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4]) ^
						(x8[(r+3)%4] ^ a[(r+3)%4]);
				else
					t[127-8*(4*c+r) -: 8] = x2[r] ^ x2[(r+1)%4] ^ a[(r+1)%4] ^
						a[(r+2)%4] ^ a[(r+3)%4];
			end
		end
		return t;
	endfunction

endpackage

[sv/aes_block_cipher.sv]
// Accept leads to a round key fetch, then the rounds, one round per cycle, then done.
// A new block is accepted only when idle; busy drops in the result cycle.
// The first block after reset or a key/length write first runs key expansion of 44, 52
// or 60 schedule words, one schedule word per cycle into the round key banks.
// Reset (arst_n low) clears key registers, length and the expanded flag.
// Results are strobed on done for one cycle; the receiver cannot stall.
module aes_block_cipher import aes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        start,
	input  logic        operation,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	output logic        busy,
	output logic        done,
	output logic [63:0] result_high,
	output logic [63:0] result_low
);

	key_regs_t  key_q;
	logic [1:0] key_len_q;
	logic [2:0] reg_idx;
	logic       wr_xfer;
	logic       key_change;
	logic [3:0] nk;
	ctrl_cmd_t  cmd;

	assign pready     = 1'b1;
	assign reg_idx    = paddr[5:3];
	assign wr_xfer    = psel && penable && pwrite && pready;
	assign key_change = wr_xfer && (reg_idx <= REG_KEYLEN);
	assign nk         = nk_of(key_len_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q     <= '0;
			key_len_q <= KLEN_128;
		end else if (wr_xfer) begin
			case (reg_idx)
				REG_KEY0:   key_q[0]  <= pwdata;
				REG_KEY1:   key_q[1]  <= pwdata;
				REG_KEY2:   key_q[2]  <= pwdata;
				REG_KEY3:   key_q[3]  <= pwdata;
				REG_KEYLEN: key_len_q <= pwdata[1:0];
				default:    key_len_q <= key_len_q;
			endcase
		end
	end

	// read-back, low address bits ignored
	always_comb begin
		case (reg_idx)
			REG_KEY0:   prdata = key_q[0];
			REG_KEY1:   prdata = key_q[1];
			REG_KEY2:   prdata = key_q[2];
			REG_KEY3:   prdata = key_q[3];
			REG_KEYLEN: prdata = {62'h0, key_len_q};
			default:    prdata = {61'h0, paddr[2:0]} & 64'h0;
		endcase
	end

	aes_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.operation  (operation),
		.key_change (key_change),
		.nk         (nk),
		.busy       (busy),
		.done       (done),
		.cmd        (cmd)
	);

	aes_dp u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.key_regs    (key_q),
		.nk          (nk),
		.block_high  (block_high),
		.block_low   (block_low),
		.result_high (result_high),
		.result_low  (result_low)
	);

endmodule

[sv/aes_ctrl.sv]
// AES controller: sequences key expansion and the cipher rounds.
// Depends on aes_pkg and aes_block_cipher_macros.svh.
`include "aes_block_cipher_macros.svh"
module aes_ctrl import aes_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       operation,
	input  logic       key_change,
	input  logic [3:0] nk,
	output logic       busy,
	output logic       done,
	output ctrl_cmd_t  cmd
);

	ctrl_state_t state_q;
	logic        expanded_q;
	logic        op_q;
	logic        done_q;
	logic [5:0]  word_q;
	logic [2:0]  mod_q;
	logic [3:0]  step_q;
	logic [3:0]  nr;
	logic [5:0]  total;

	assign nr    = nk + 4'd6;
	assign total = {nk, 2'b00} + 6'd28;
	assign busy  = (state_q != ST_IDLE);
	assign done  = done_q;

	// command decode
	always_comb begin
		cmd           = '0;
		cmd.word_idx  = word_q;
		cmd.from_key  = ({2'b00, word_q[5:2]} < {2'b00, nk[3:2]}) ||
			(word_q < {2'b00, nk});
		cmd.mod_zero  = (mod_q == 3'd0);
		cmd.mod_four  = (mod_q == 3'd4) && (nk == 4'd8);
		cmd.dec       = op_q;
		cmd.rnd_first = (step_q == 4'd0);
		cmd.rnd_last  = (step_q == nr);
		case (state_q)
			ST_IDLE: begin
				cmd.load_blk = start;
			end
			ST_EXPAND: begin
				cmd.exp_we = 1'b1;
			end
			ST_FETCH: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_row = op_q ? nr : 4'd0;
			end
			ST_ROUND: begin
				cmd.rnd_en = 1'b1;
				cmd.rd_en  = (step_q != nr);
				cmd.rd_row = op_q ? (nr - step_q - 4'd1) : (step_q + 4'd1);
			end
			default: begin
				cmd.load_blk = 1'b0;
			end
		endcase
	end

	// state machine and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			expanded_q <= 1'b0;
			op_q       <= 1'b0;
			done_q     <= 1'b0;
			word_q     <= '0;
			mod_q      <= '0;
			step_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (key_change)
				expanded_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q   <= operation;
						word_q <= '0;
						mod_q  <= '0;
						state_q <= expanded_q ? ST_FETCH : ST_EXPAND;
					end
				end
				ST_EXPAND: begin
					word_q <= word_q + 6'd1;
					mod_q  <= ({1'b0, mod_q} == nk - 4'd1) ? 3'd0 : mod_q + 3'd1;
					if (word_q == total - 6'd1) begin
						expanded_q <= 1'b1;
						state_q    <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					step_q  <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					step_q <= step_q + 4'd1;
					if (step_q == nr) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`AES_IMPLY(a_fetch_keys_ready, state_q == ST_FETCH, expanded_q, "round keys not expanded")
	`AES_NEXT(a_done_after_last, state_q == ST_ROUND && step_q == nr, done_q && state_q == ST_IDLE, "no result after last round")
	`AES_NEXT(a_expand_on_stale, state_q == ST_IDLE && start && !expanded_q, state_q == ST_EXPAND, "stale keys not expanded")
	`AES_IMPLY(a_expand_bound, state_q == ST_EXPAND, word_q < total, "expansion ran past schedule")

endmodule

[sv/aes_dp.sv]
// AES datapath: key schedule, round key banks, one-round-per-cycle state.
// Depends on aes_pkg; driven by aes_ctrl commands.
module aes_dp import aes_pkg::*; (
	input  logic        clk,
	input  ctrl_cmd_t   cmd,
	input  key_regs_t   key_regs,
	input  logic [3:0]  nk,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	output logic [63:0] result_high,
	output logic [63:0] result_low
);

	logic [31:0]  win_q [8];
	logic [7:0]   rcon_q;
	logic [31:0]  rk_mem [4][15];
	logic [31:0]  rk_rd_q [4];
	logic [127:0] state_q;
	logic [31:0]  key_word;
	logic [31:0]  t_word;
	logic [31:0]  new_word;
	logic [2:0]   nk_m1;
	logic [127:0] rk;
	logic [127:0] nxt;
	logic [127:0] tmp;

	// next schedule word
	assign nk_m1    = 3'(nk - 4'd1);
	assign key_word = cmd.word_idx[0] ? key_regs[cmd.word_idx[2:1]][31:0]
		: key_regs[cmd.word_idx[2:1]][63:32];
	always_comb begin
		if (cmd.mod_zero)
			t_word = sub_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rcon_q, 24'h0};
		else if (cmd.mod_four)
			t_word = sub_word(win_q[0]);
		else
			t_word = win_q[0];
		new_word = cmd.from_key ? key_word : (win_q[nk_m1] ^ t_word);
	end

	// word window and round constant
	always_ff @(posedge clk) begin
		if (cmd.exp_we) begin
			win_q[0] <= new_word;
			for (int i = 1; i < 8; i++)
				win_q[i] <= win_q[i-1];
			if (cmd.from_key)
				rcon_q <= 8'h01;
			else if (cmd.mod_zero)
				rcon_q <= xt(rcon_q);
		end
	end

	// round key banks: word i in bank i%4, row i/4
	for (genvar b = 0; b < 4; b++) begin : g_bank
		always_ff @(posedge clk) begin
			if (cmd.exp_we && cmd.word_idx[1:0] == 2'(b))
				rk_mem[b][cmd.word_idx[5:2]] <= new_word;
			if (cmd.rd_en)
				rk_rd_q[b] <= rk_mem[b][cmd.rd_row];
		end
	end

	// one round of the cipher
	assign rk = {rk_rd_q[0], rk_rd_q[1], rk_rd_q[2], rk_rd_q[3]};
	always_comb begin
		tmp = '0;
		if (!cmd.dec) begin
			if (cmd.rnd_first) begin
				nxt = state_q ^ rk;
			end else begin
				tmp = shift_rows(sub_bytes(state_q, 1'b0), 1'b0);
				if (!cmd.rnd_last)
					tmp = mix_columns(tmp, 1'b0);
				nxt = tmp ^ rk;
			end
		end else begin
			if (cmd.rnd_last) begin
				nxt = state_q ^ rk;
			end else begin
				tmp = state_q ^ rk;
				if (!cmd.rnd_first)
					tmp = mix_columns(tmp, 1'b1);
				nxt = sub_bytes(shift_rows(tmp, 1'b1), 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_blk)
			state_q <= {block_high, block_low};
		else if (cmd.rnd_en)
			state_q <= nxt;
	end

	assign result_high = state_q[127:64];
	assign result_low  = state_q[63:0];

endmodule
